### src/eevdf_pkg.sv
// Shared types, codes and helpers for the deadline run queue.
package eevdf_pkg;

   localparam int SLOT_W = 6;
   localparam int RT_W   = 32;
   localparam int WT_W   = 17;
   localparam int VT_W   = 48;
   localparam int CNT_W  = 7;
   localparam int UNIT_SHIFT = 10;                 // scaling by 1024
   localparam int QUO_W  = RT_W + UNIT_SHIFT;      // scaled amount width

   typedef enum logic [2:0] {
      FN_ADD    = 3'd0,
      FN_REMOVE = 3'd1,
      FN_UPDATE = 3'd2,
      FN_POP    = 3'd3,
      FN_PEEK   = 3'd4,
      FN_CLEAR  = 3'd5
   } func_type;

   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_EMPTY = 2'd1;
   localparam logic [1:0] STAT_SLOT  = 2'd2;
   localparam logic [1:0] STAT_WT    = 2'd3;

   typedef struct packed {
      logic [2:0]        func;
      logic [SLOT_W-1:0] slot;
      logic              slot_ok;
      logic [RT_W-1:0]   run_time;
      logic [WT_W-1:0]   weight;
      logic              weight_zero;
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_UPD_RD,
      ST_DIV,
      ST_ADD_VT,
      ST_ADD_WR,
      ST_UPD_WR,
      ST_SCAN,
      ST_SCAN_FIN,
      ST_RESP
   } back_state_type;

   function automatic logic [VT_W-1:0] sat_add48(input logic [VT_W-1:0] a,
                                                 input logic [VT_W-1:0] b);
      logic [VT_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[VT_W] ? {VT_W{1'b1}} : s[VT_W-1:0];
   endfunction

endpackage

### src/eevdf_deadline_run_queue_unit.sv
// Top level of the virtual deadline run queue.
// Request channel (req_*): func, thread_slot, run_time, thread_weight; a
// transaction is taken when req_valid is high and req_stall low. Response
// channel (rsp_*): one transaction per request, in order, with status, the
// picked slot and deadline, queue count, empty flag and virtual time.
// Requests land in a two-entry queue and are executed one at a time.
// Add and update, when accepted, run the 42-step bit-serial divide by
// weight; pop and peek scan the deadline store with one read per slot;
// remove, clear and unknown codes go straight to the response.
// The response register holds a finished result while the next request
// executes up to its own response; a stalled response holds its payload
// and the queue then fills and raises req_stall.
// Reset (synchronous) empties the queue, clears all slot flags, the count and
// the virtual time; the slot stores keep their contents and need no sweep.
module eevdf_deadline_run_queue_unit
   import eevdf_pkg::*;
#(
   parameter int SLOTS = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [2:0]        req_func,
   input  logic [SLOT_W-1:0] req_thread_slot,
   input  logic [RT_W-1:0]   req_run_time,
   input  logic [WT_W-1:0]   req_thread_weight,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [1:0]        rsp_status,
   output logic [SLOT_W-1:0] rsp_picked_slot,
   output logic [VT_W-1:0]   rsp_picked_deadline,
   output logic [CNT_W-1:0]  rsp_queue_count,
   output logic              rsp_is_empty,
   output logic [VT_W-1:0]   rsp_virtual_time_out
);

   logic    q_valid;
   logic    q_pop;
   cmd_type q_cmd;

   eevdf_front #(.SLOTS(SLOTS)) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_func          (req_func),
      .req_thread_slot   (req_thread_slot),
      .req_run_time      (req_run_time),
      .req_thread_weight (req_thread_weight),
      .q_valid           (q_valid),
      .q_pop             (q_pop),
      .q_cmd             (q_cmd)
   );

   eevdf_back #(.SLOTS(SLOTS)) u_back (
      .clock                (clock),
      .reset                (reset),
      .q_valid              (q_valid),
      .q_pop                (q_pop),
      .q_cmd                (q_cmd),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_status           (rsp_status),
      .rsp_picked_slot      (rsp_picked_slot),
      .rsp_picked_deadline  (rsp_picked_deadline),
      .rsp_queue_count      (rsp_queue_count),
      .rsp_is_empty         (rsp_is_empty),
      .rsp_virtual_time_out (rsp_virtual_time_out)
   );

endmodule

### src/eevdf_front.sv
// Front end: accepts request transactions, classifies them and queues them.
module eevdf_front
   import eevdf_pkg::*;
#(
   parameter int SLOTS = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [2:0]        req_func,
   input  logic [SLOT_W-1:0] req_thread_slot,
   input  logic [RT_W-1:0]   req_run_time,
   input  logic [WT_W-1:0]   req_thread_weight,
   output logic              q_valid,
   input  logic              q_pop,
   output cmd_type           q_cmd
);

   cmd_type    buf_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] cnt_ff;
   logic       push;
   cmd_type    cmd_in;

   always_comb begin
      cmd_in.func        = req_func;
      cmd_in.slot        = req_thread_slot;
      cmd_in.slot_ok     = 32'(req_thread_slot) < SLOTS;
      cmd_in.run_time    = req_run_time;
      cmd_in.weight      = req_thread_weight;
      cmd_in.weight_zero = req_thread_weight == '0;
   end

   assign req_stall = cnt_ff == 2'd2;
   assign push      = req_valid && !req_stall;
   assign q_valid   = cnt_ff != 2'd0;
   assign q_cmd     = buf_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         buf_ff[wr_ptr_ff] <= cmd_in;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (q_pop) rd_ptr_ff <= !rd_ptr_ff;
         cnt_ff <= 2'(cnt_ff + {1'b0, push} - {1'b0, q_pop});
      end
   end

endmodule

### src/eevdf_div.sv
// Restoring divider, one quotient bit per cycle.
module eevdf_div
   import eevdf_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [QUO_W-1:0] dividend,
   input  logic [WT_W-1:0]  divisor,
   output logic             busy,
   output logic             done,
   output logic [QUO_W-1:0] quotient
);

   localparam int CW = $clog2(QUO_W);

   logic [WT_W-1:0]  rem_ff, rem_in;
   logic [WT_W-1:0]  dvs_ff;
   logic [QUO_W-1:0] quo_ff;
   logic [CW-1:0]    cnt_ff;
   logic             busy_ff, done_ff;
   logic [WT_W:0]    rem_sh;
   logic             ge;

   always_comb begin
      rem_sh = {rem_ff, quo_ff[QUO_W-1]};
      ge     = rem_sh >= {1'b0, dvs_ff};
      rem_in = ge ? WT_W'(rem_sh - {1'b0, dvs_ff}) : rem_sh[WT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         dvs_ff <= divisor;
         cnt_ff <= '0;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= {quo_ff[QUO_W-2:0], ge};
         cnt_ff <= CW'(cnt_ff + 1'b1);
      end
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= busy_ff && !start && cnt_ff == CW'(QUO_W - 1);
         if (start) busy_ff <= 1'b1;
         else if (cnt_ff == CW'(QUO_W - 1)) busy_ff <= 1'b0;
      end
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

### src/eevdf_back.sv
// Back end: slot stores, deadline scan, virtual time and the response register.
module eevdf_back
   import eevdf_pkg::*;
#(
   parameter int SLOTS = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   output logic              q_pop,
   input  cmd_type           q_cmd,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [1:0]        rsp_status,
   output logic [SLOT_W-1:0] rsp_picked_slot,
   output logic [VT_W-1:0]   rsp_picked_deadline,
   output logic [CNT_W-1:0]  rsp_queue_count,
   output logic              rsp_is_empty,
   output logic [VT_W-1:0]   rsp_virtual_time_out
);

   localparam int SW = $clog2(SLOTS);

   logic [VT_W-1:0] rt_mem [SLOTS];
   logic [WT_W-1:0] wt_mem [SLOTS];
   logic [VT_W-1:0] dl_mem [SLOTS];

   back_state_type   state_ff, state_in;
   cmd_type          cmd_ff, cmd_in;
   logic [VT_W-1:0]  vt_ff, vt_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [SLOTS-1:0] queued_ff, queued_in;
   logic [SW:0]      scan_ff, scan_in;
   logic             pend_ok_ff, pend_ok_in;
   logic [SW-1:0]    pend_idx_ff, pend_idx_in;
   logic             found_ff, found_in;
   logic [SW-1:0]    best_idx_ff, best_idx_in;
   logic [VT_W-1:0]  best_dl_ff, best_dl_in;
   logic [1:0]       res_status_ff, res_status_in;
   logic [SLOT_W-1:0] res_slot_ff, res_slot_in;
   logic [VT_W-1:0]  res_dl_ff, res_dl_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_load;

   logic [VT_W-1:0]  rsp_status_pad;
   logic [1:0]       rsp_status_ff;
   logic [SLOT_W-1:0] rsp_slot_ff;
   logic [VT_W-1:0]  rsp_dl_ff;
   logic [CNT_W-1:0] rsp_count_ff;
   logic             rsp_empty_ff;
   logic [VT_W-1:0]  rsp_vt_ff;

   logic [SW-1:0]    idx;
   logic [SW-1:0]    rd_addr;
   logic [VT_W-1:0]  rd_rt_ff, rd_dl_ff;
   logic [WT_W-1:0]  rd_wt_ff;
   logic             mem_we;
   logic [VT_W-1:0]  wr_rt, wr_dl;
   logic [WT_W-1:0]  wr_wt;

   logic             div_start, div_busy, div_done;
   logic [WT_W-1:0]  div_divisor;
   logic [QUO_W-1:0] div_quo;
   logic [VT_W-1:0]  vr;

   assign idx         = SW'(cmd_ff.slot);
   assign vr          = VT_W'(div_quo);
   assign div_divisor = (cmd_ff.func == FN_ADD) ? cmd_ff.weight : rd_wt_ff;
   assign rsp_status_pad = '0;

   eevdf_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({cmd_ff.run_time, {UNIT_SHIFT{1'b0}}}),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      vt_in         = vt_ff;
      count_in      = count_ff;
      queued_in     = queued_ff;
      scan_in       = scan_ff;
      pend_ok_in    = 1'b0;
      pend_idx_in   = pend_idx_ff;
      found_in      = found_ff;
      best_idx_in   = best_idx_ff;
      best_dl_in    = best_dl_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_dl_in     = res_dl_ff;
      rsp_load      = 1'b0;
      q_pop         = 1'b0;
      div_start     = 1'b0;
      mem_we        = 1'b0;
      rd_addr       = idx;
      wr_rt         = 48'(cmd_ff.run_time);
      wr_wt         = cmd_ff.weight;
      wr_dl         = sat_add48(vt_ff, vr);

      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop         = 1'b1;
               cmd_in        = q_cmd;
               res_status_in = STAT_OK;
               res_slot_in   = '0;
               res_dl_in     = '0;
               state_in      = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            state_in = ST_RESP;
            case (cmd_ff.func)
               FN_ADD: begin
                  if (!cmd_ff.slot_ok || queued_ff[idx]) begin
                     res_status_in = STAT_SLOT;
                  end else if (cmd_ff.weight_zero) begin
                     res_status_in = STAT_WT;
                  end else begin
                     div_start = 1'b1;
                     state_in  = ST_DIV;
                  end
               end
               FN_REMOVE: begin
                  if (!cmd_ff.slot_ok || !queued_ff[idx]) begin
                     res_status_in = STAT_SLOT;
                  end else begin
                     queued_in[idx] = 1'b0;
                     count_in       = CNT_W'(count_ff - 1'b1);
                  end
               end
               FN_UPDATE: begin
                  if (!cmd_ff.slot_ok || !queued_ff[idx]) begin
                     res_status_in = STAT_SLOT;
                  end else begin
                     state_in = ST_UPD_RD;
                  end
               end
               FN_POP, FN_PEEK: begin
                  scan_in  = '0;
                  found_in = 1'b0;
                  state_in = ST_SCAN;
               end
               FN_CLEAR: begin
                  queued_in = '0;
                  count_in  = '0;
               end
               default: begin
               end
            endcase
         end
         ST_UPD_RD: begin
            if (rd_wt_ff == '0) begin
               res_status_in = STAT_WT;
               state_in      = ST_RESP;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = (cmd_ff.func == FN_ADD) ? ST_ADD_VT : ST_UPD_WR;
            end
         end
         ST_ADD_VT: begin
            if (vr > vt_ff) vt_in = vr;
            state_in = ST_ADD_WR;
         end
         ST_ADD_WR: begin
            mem_we         = 1'b1;
            queued_in[idx] = 1'b1;
            count_in       = CNT_W'(count_ff + 1'b1);
            state_in       = ST_RESP;
         end
         ST_UPD_WR: begin
            mem_we   = 1'b1;
            wr_rt    = sat_add48(rd_rt_ff, 48'(cmd_ff.run_time));
            wr_wt    = rd_wt_ff;
            wr_dl    = sat_add48(rd_dl_ff, vr);
            state_in = ST_RESP;
         end
         ST_SCAN: begin
            // one address issued a cycle; its data is compared the cycle after
            rd_addr = scan_ff[SW-1:0];
            if (pend_ok_ff && (!found_ff || rd_dl_ff < best_dl_ff)) begin
               found_in    = 1'b1;
               best_idx_in = pend_idx_ff;
               best_dl_in  = rd_dl_ff;
            end
            if (scan_ff == (SW+1)'(SLOTS)) begin
               state_in = ST_SCAN_FIN;
            end else begin
               pend_ok_in  = queued_ff[scan_ff[SW-1:0]];
               pend_idx_in = scan_ff[SW-1:0];
               scan_in     = (SW+1)'(scan_ff + 1'b1);
            end
         end
         ST_SCAN_FIN: begin
            state_in = ST_RESP;
            if (!found_ff) begin
               res_status_in = STAT_EMPTY;
            end else begin
               res_slot_in = SLOT_W'(best_idx_ff);
               res_dl_in   = best_dl_ff;
               if (cmd_ff.func == FN_POP) begin
                  queued_in[best_idx_ff] = 1'b0;
                  count_in = CNT_W'(count_ff - 1'b1);
                  if (best_dl_ff > vt_ff) vt_in = best_dl_ff;
               end
            end
         end
         ST_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         rt_mem[idx] <= wr_rt;
         wt_mem[idx] <= wr_wt;
         dl_mem[idx] <= wr_dl;
      end
      rd_rt_ff <= rt_mem[rd_addr];
      rd_wt_ff <= wt_mem[rd_addr];
      rd_dl_ff <= dl_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      scan_ff       <= scan_in;
      pend_idx_ff   <= pend_idx_in;
      best_idx_ff   <= best_idx_in;
      best_dl_ff    <= best_dl_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_dl_ff     <= res_dl_in;
      if (rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_slot_ff   <= res_slot_ff;
         rsp_dl_ff     <= res_dl_ff | rsp_status_pad;
         rsp_count_ff  <= count_ff;
         rsp_empty_ff  <= count_ff == '0;
         rsp_vt_ff     <= vt_ff;
      end
      if (reset) begin
         state_ff     <= ST_IDLE;
         vt_ff        <= '0;
         count_ff     <= '0;
         queued_ff    <= '0;
         pend_ok_ff   <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         vt_ff        <= vt_in;
         count_ff     <= count_in;
         queued_ff    <= queued_in;
         pend_ok_ff   <= pend_ok_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_picked_slot      = rsp_slot_ff;
   assign rsp_picked_deadline  = rsp_dl_ff;
   assign rsp_queue_count      = rsp_count_ff;
   assign rsp_is_empty         = rsp_empty_ff;
   assign rsp_virtual_time_out = rsp_vt_ff;

   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      $countones(queued_ff) == int'(count_ff))
      else $error("queued count disagrees with slot flags");

   a_div_only_in_div: assert property (@(posedge clock) disable iff (reset)
      div_busy |-> state_ff == ST_DIV)
      else $error("divider running outside the divide state");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> scan_ff <= (SW+1)'(SLOTS))
      else $error("scan index overran the slot range");

   a_pop_from_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> state_ff == ST_DISPATCH)
      else $error("command taken without dispatch");

endmodule
